>>> src/assert_macros.svh
// Assertion helpers shared by the RTL files.
// Each macro expects a clock named clk and an active-low reset named rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset.
`define ASSERT_NEVER(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`endif

>>> src/uvsph_pkg.sv
// ----------------------------------------------------------------------------
// uvsph_pkg
// Shared types, constants and arithmetic helpers of the UV-sphere mesh generator.
// ----------------------------------------------------------------------------
package uvsph_pkg;

  localparam int MAX_DIVISIONS = 256;

  localparam int RAD_W    = 16;
  localparam int CNT_W    = 9;
  localparam int IDX_W    = 9;
  localparam int POS_W    = 17;
  localparam int NRM_W    = 16;
  localparam int CRN_W    = 17;
  localparam int KIND_W   = 2;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DAT_W = 16;

  // Angle phase in 2^-24 turns, quarter turn at bit 22
  localparam int PHASE_W  = 24;
  localparam int QTR_BITS = 22;
  localparam int QUO_W    = 25;
  localparam int REM_W    = 10;

  // Q30 polynomial datapath
  localparam int Q30_W = 31;
  localparam logic [Q30_W-1:0] ONE_Q30 = 31'h4000_0000;
  localparam logic [Q30_W-1:0] K_A1 = 31'd1686629713;
  localparam logic [Q30_W-1:0] K_A3 = 31'd693598668;
  localparam logic [Q30_W-1:0] K_A5 = 31'd85569306;
  localparam logic [Q30_W-1:0] K_A7 = 31'd5026995;
  localparam logic [Q30_W-1:0] K_A9 = 31'd172272;
  localparam int HORNER_STEPS = 4;
  localparam logic [Q30_W-1:0] K_HORNER [HORNER_STEPS] = '{K_A7, K_A5, K_A3, K_A1};
  localparam logic [NRM_W-1:0] Q14_ONE = 16'd16384;

  // Pipeline depths
  localparam int FIFO_DEPTH   = 4;
  localparam int FIFO_AW      = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW      = $clog2(FIFO_DEPTH + 1);
  localparam int DIV_STAGES   = QUO_W;
  localparam int SINE_STAGES  = 3 + HORNER_STEPS;
  localparam int SCALE_STAGES = 2;
  localparam int SB_STAGES    = DIV_STAGES + SINE_STAGES + SCALE_STAGES;

  typedef enum logic [KIND_W-1:0] {
    KIND_VERTEX = 2'd0,
    KIND_TRI    = 2'd1,
    KIND_ERR    = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIUS    = 2'd0,
    REG_LAT_COUNT = 2'd1,
    REG_LON_COUNT = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    kind_t             kind;
    logic [IDX_W-1:0]  lat;
    logic [IDX_W-1:0]  lon;
    logic [CRN_W-1:0]  first;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_link_t;

  // Q30 product rounded half up
  function automatic logic [Q30_W:0] mul_q30(input logic [Q30_W-1:0] a,
                                             input logic [Q30_W-1:0] b);
    logic [2*Q30_W-1:0] p;
    p = (62'(a) * 62'(b)) + (62'(1) << 29);
    return p[2*Q30_W-1:30];
  endfunction

endpackage

>>> src/uv_sphere_mesh_generator.sv
// ----------------------------------------------------------------------------
// uv_sphere_mesh_generator
// UV-sphere vertex and triangle-index generator.
// ----------------------------------------------------------------------------
// Requests: drive in_func/in_lat_index/in_lon_index with start; the request
// transfers at a clock edge with start high and busy low. busy rises only
// when the four-entry request queue is full.
// Results: each result sits on the out_ ports for one cycle with out_strobe
// high; out_last marks the final result of a request. The receiver cannot
// stall the block.
// Pipeline: a request passes the dequeue register, the 25-stage angle dividers,
// the 7-stage sine units, two scaling stages and the result register.
// Throughput: one vertex or error request per cycle; a quad request emits two
// triangles on consecutive cycles and holds the pipeline while the second goes out.
// Configuration: cfg_index selects radius (0), latitude count (1) or
// longitude count (2); cfg_ready is always high. Write only while idle.
// Reset (synchronous, active low) empties the queue and pipeline and loads
// radius 1.0, 16 latitude bands and 32 longitude segments.
// ----------------------------------------------------------------------------
module uv_sphere_mesh_generator (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  logic                                in_func,
  input  logic [uvsph_pkg::IDX_W-1:0]         in_lat_index,
  input  logic [uvsph_pkg::IDX_W-1:0]         in_lon_index,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [uvsph_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [uvsph_pkg::CFG_DAT_W-1:0]     cfg_data,
  output logic                                out_strobe,
  output logic [uvsph_pkg::KIND_W-1:0]        out_result_kind,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_z,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_x,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_y,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_z,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_a,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_b,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_c,
  output logic                                out_last
);

  logic [uvsph_pkg::RAD_W-1:0] radius_r;
  logic [uvsph_pkg::CNT_W-1:0] lat_count_r;
  logic [uvsph_pkg::CNT_W-1:0] lon_count_r;
  uvsph_pkg::q_link_t          head;
  logic                        pop;

  assign cfg_ready = 1'b1;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r    <= 16'd256;
      lat_count_r <= 9'd16;
      lon_count_r <= 9'd32;
    end else if (cfg_valid && cfg_ready) begin
      unique case (uvsph_pkg::cfg_reg_t'(cfg_index))
        uvsph_pkg::REG_RADIUS:    radius_r    <= cfg_data;
        uvsph_pkg::REG_LAT_COUNT: lat_count_r <= cfg_data[uvsph_pkg::CNT_W-1:0];
        uvsph_pkg::REG_LON_COUNT: lon_count_r <= cfg_data[uvsph_pkg::CNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  uvsph_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_func      (in_func),
    .in_lat_index (in_lat_index),
    .in_lon_index (in_lon_index),
    .lat_count    (lat_count_r),
    .lon_count    (lon_count_r),
    .pop          (pop),
    .head         (head)
  );

  uvsph_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .pop             (pop),
    .sphere_radius   (radius_r),
    .lat_count       (lat_count_r),
    .lon_count       (lon_count_r),
    .out_strobe      (out_strobe),
    .out_result_kind (out_result_kind),
    .out_pos_x       (out_pos_x),
    .out_pos_y       (out_pos_y),
    .out_pos_z       (out_pos_z),
    .out_norm_x      (out_norm_x),
    .out_norm_y      (out_norm_y),
    .out_norm_z      (out_norm_z),
    .out_corner_a    (out_corner_a),
    .out_corner_b    (out_corner_b),
    .out_corner_c    (out_corner_c),
    .out_last        (out_last)
  );

endmodule

>>> src/uvsph_front.sv
// ----------------------------------------------------------------------------
// uvsph_front
// Accepts requests, checks index ranges, forms the quad base index and
// queues the classified item for the back end.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uvsph_front (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic                          in_func,
  input  logic [uvsph_pkg::IDX_W-1:0]   in_lat_index,
  input  logic [uvsph_pkg::IDX_W-1:0]   in_lon_index,
  input  logic [uvsph_pkg::CNT_W-1:0]   lat_count,
  input  logic [uvsph_pkg::CNT_W-1:0]   lon_count,
  input  logic                          pop,
  output uvsph_pkg::q_link_t            head
);

  logic                           counts_ok;
  logic                           range_ok;
  logic                           push;
  logic                           do_pop;
  logic [uvsph_pkg::CRN_W-1:0]    lonp1;
  uvsph_pkg::item_t               item_in;
  uvsph_pkg::item_t               mem_r [uvsph_pkg::FIFO_DEPTH];
  logic [uvsph_pkg::FIFO_AW-1:0]  wr_ptr_r;
  logic [uvsph_pkg::FIFO_AW-1:0]  rd_ptr_r;
  logic [uvsph_pkg::FIFO_CW-1:0]  cnt_r;

  // Classify the request
  always_comb begin
    counts_ok = (lat_count != '0) && (lon_count != '0) &&
                (int'(lat_count) <= uvsph_pkg::MAX_DIVISIONS) &&
                (int'(lon_count) <= uvsph_pkg::MAX_DIVISIONS);
    if (in_func == 1'b0) begin
      range_ok = (in_lat_index <= lat_count) && (in_lon_index <= lon_count);
    end else begin
      range_ok = (in_lat_index < lat_count) && (in_lon_index < lon_count);
    end
    lonp1         = uvsph_pkg::CRN_W'(lon_count) + 17'd1;
    item_in.lat   = in_lat_index;
    item_in.lon   = in_lon_index;
    item_in.first = uvsph_pkg::CRN_W'(uvsph_pkg::CRN_W'(in_lat_index) * lonp1 +
                                      uvsph_pkg::CRN_W'(in_lon_index));
    if (!(counts_ok && range_ok)) begin
      item_in.kind = uvsph_pkg::KIND_ERR;
    end else if (in_func) begin
      item_in.kind = uvsph_pkg::KIND_TRI;
    end else begin
      item_in.kind = uvsph_pkg::KIND_VERTEX;
    end
  end

  // Queue handshake
  assign busy       = (cnt_r == uvsph_pkg::FIFO_CW'(uvsph_pkg::FIFO_DEPTH));
  assign push       = start && !busy;
  assign head.valid = (cnt_r != '0);
  assign head.item  = mem_r[rd_ptr_r];
  assign do_pop     = pop && head.valid;

  // Store entry on transfer
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= item_in;
    end
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      cnt_r <= cnt_r + uvsph_pkg::FIFO_CW'(push) - uvsph_pkg::FIFO_CW'(do_pop);
    end
  end

  `ASSERT_NEVER(a_fifo_overfill, cnt_r > uvsph_pkg::FIFO_CW'(uvsph_pkg::FIFO_DEPTH), "queue overfilled")
  `ASSERT_CLK(a_fifo_ptr_empty, (cnt_r == '0) |-> (rd_ptr_r == wr_ptr_r), "empty queue with pointer gap")

endmodule

>>> src/uvsph_div.sv
// ----------------------------------------------------------------------------
// uvsph_div
// Pipelined restoring divider, one quotient bit per stage, giving an angle
// phase from an index and a division count.
// ----------------------------------------------------------------------------
module uvsph_div (
  input  logic                            clk,
  input  logic                            en,
  input  logic [uvsph_pkg::REM_W-1:0]     rem_in,
  input  logic [uvsph_pkg::QUO_W-1:0]     num_in,
  input  logic [uvsph_pkg::REM_W-1:0]     den,
  output logic [uvsph_pkg::PHASE_W-1:0]   phase
);

  logic [uvsph_pkg::REM_W-1:0] rem_r [uvsph_pkg::DIV_STAGES];
  logic [uvsph_pkg::QUO_W-1:0] num_r [uvsph_pkg::DIV_STAGES];
  logic [uvsph_pkg::QUO_W-1:0] quo_r [uvsph_pkg::DIV_STAGES];

  for (genvar s = 0; s < uvsph_pkg::DIV_STAGES; s++) begin : g_stage
    logic [uvsph_pkg::REM_W-1:0] rem_prev;
    logic [uvsph_pkg::QUO_W-1:0] num_prev;
    logic [uvsph_pkg::QUO_W-1:0] quo_prev;
    logic [uvsph_pkg::REM_W:0]   trial;
    logic [uvsph_pkg::REM_W:0]   diff;
    logic                        take;

    if (s == 0) begin : g_first
      assign rem_prev = rem_in;
      assign num_prev = num_in;
      assign quo_prev = '0;
    end else begin : g_next
      assign rem_prev = rem_r[s-1];
      assign num_prev = num_r[s-1];
      assign quo_prev = quo_r[s-1];
    end

    // Shift in the next numerator bit and trial-subtract
    always_comb begin
      trial = {rem_prev, num_prev[uvsph_pkg::QUO_W-1]};
      diff  = trial - {1'b0, den};
      take  = (trial >= {1'b0, den});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= take ? diff[uvsph_pkg::REM_W-1:0] : trial[uvsph_pkg::REM_W-1:0];
        quo_r[s] <= {quo_prev[uvsph_pkg::QUO_W-2:0], take};
        num_r[s] <= {num_prev[uvsph_pkg::QUO_W-2:0], 1'b0};
      end
    end
  end

  // Phase wraps modulo one turn
  assign phase = quo_r[uvsph_pkg::DIV_STAGES-1][uvsph_pkg::PHASE_W-1:0];

endmodule

>>> src/uvsph_sine.sv
// ----------------------------------------------------------------------------
// uvsph_sine
// Pipelined sine of a 24-bit phase: quadrant fold, Q30 odd polynomial in
// Horner form with one multiply per stage, Q1.14 result.
// ----------------------------------------------------------------------------
module uvsph_sine (
  input  logic                                clk,
  input  logic                                en,
  input  logic [uvsph_pkg::PHASE_W-1:0]       phase,
  output logic signed [uvsph_pkg::NRM_W-1:0]  value
);

  logic [uvsph_pkg::Q30_W-1:0] x0;
  logic [uvsph_pkg::Q30_W-1:0] x1_r;
  logic                        neg1_r;
  logic [uvsph_pkg::Q30_W-1:0] x2_r;
  logic [uvsph_pkg::Q30_W-1:0] xa_r;
  logic                        nega_r;
  logic [uvsph_pkg::Q30_W-1:0] t_r   [uvsph_pkg::HORNER_STEPS];
  logic [uvsph_pkg::Q30_W-1:0] hx2_r [uvsph_pkg::HORNER_STEPS];
  logic [uvsph_pkg::Q30_W-1:0] hx_r  [uvsph_pkg::HORNER_STEPS];
  logic                        hneg_r[uvsph_pkg::HORNER_STEPS];
  logic [uvsph_pkg::Q30_W:0]   fin_prod;
  logic [uvsph_pkg::Q30_W+1:0] fin_round;
  logic [uvsph_pkg::NRM_W:0]   fin_mag;
  logic [uvsph_pkg::NRM_W-1:0] mag_sat;
  logic signed [uvsph_pkg::NRM_W-1:0] value_r;

  // Fold phase into a quarter-turn fraction, mirrored in odd quadrants
  always_comb begin
    x0 = {1'b0, phase[uvsph_pkg::QTR_BITS-1:0], 8'b0};
    if (phase[uvsph_pkg::QTR_BITS]) begin
      x0 = uvsph_pkg::ONE_Q30 - x0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x1_r   <= x0;
      neg1_r <= phase[uvsph_pkg::QTR_BITS+1];
    end
  end

  // Square
  always_ff @(posedge clk) begin
    if (en) begin
      x2_r   <= uvsph_pkg::Q30_W'(uvsph_pkg::mul_q30(x1_r, x1_r));
      xa_r   <= x1_r;
      nega_r <= neg1_r;
    end
  end

  // Horner steps, one product each
  for (genvar h = 0; h < uvsph_pkg::HORNER_STEPS; h++) begin : g_horner
    logic [uvsph_pkg::Q30_W-1:0] t_prev;
    logic [uvsph_pkg::Q30_W-1:0] x2_prev;
    logic [uvsph_pkg::Q30_W-1:0] x_prev;
    logic                        neg_prev;

    if (h == 0) begin : g_first
      assign t_prev   = uvsph_pkg::K_A9;
      assign x2_prev  = x2_r;
      assign x_prev   = xa_r;
      assign neg_prev = nega_r;
    end else begin : g_next
      assign t_prev   = t_r[h-1];
      assign x2_prev  = hx2_r[h-1];
      assign x_prev   = hx_r[h-1];
      assign neg_prev = hneg_r[h-1];
    end

    always_ff @(posedge clk) begin
      if (en) begin
        t_r[h]    <= uvsph_pkg::Q30_W'({1'b0, uvsph_pkg::K_HORNER[h]} -
                                       uvsph_pkg::mul_q30(x2_prev, t_prev));
        hx2_r[h]  <= x2_prev;
        hx_r[h]   <= x_prev;
        hneg_r[h] <= neg_prev;
      end
    end
  end

  // Final product, round to Q1.14, clamp, apply quadrant sign
  always_comb begin
    fin_prod  = uvsph_pkg::mul_q30(hx_r[uvsph_pkg::HORNER_STEPS-1],
                                   t_r[uvsph_pkg::HORNER_STEPS-1]);
    fin_round = {1'b0, fin_prod} + 33'd32768;
    fin_mag   = fin_round[uvsph_pkg::Q30_W+1:16];
    mag_sat   = (fin_mag > {1'b0, uvsph_pkg::Q14_ONE}) ? uvsph_pkg::Q14_ONE
                                                       : fin_mag[uvsph_pkg::NRM_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      value_r <= hneg_r[uvsph_pkg::HORNER_STEPS-1] ? -$signed(mag_sat) : $signed(mag_sat);
    end
  end

  assign value = value_r;

endmodule

>>> src/uvsph_back.sv
// ----------------------------------------------------------------------------
// uvsph_back
// Executes queued items: angle dividers, four sine units, position and
// normal scaling, and the result register that splits a quad into two
// triangles.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module uvsph_back (
  input  logic                                clk,
  input  logic                                rst_n,
  input  uvsph_pkg::q_link_t                  head,
  output logic                                pop,
  input  logic [uvsph_pkg::RAD_W-1:0]         sphere_radius,
  input  logic [uvsph_pkg::CNT_W-1:0]         lat_count,
  input  logic [uvsph_pkg::CNT_W-1:0]         lon_count,
  output logic                                out_strobe,
  output logic [uvsph_pkg::KIND_W-1:0]        out_result_kind,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_x,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_y,
  output logic signed [uvsph_pkg::POS_W-1:0]  out_pos_z,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_x,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_y,
  output logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_z,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_a,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_b,
  output logic [uvsph_pkg::CRN_W-1:0]         out_corner_c,
  output logic                                out_last
);

  typedef struct packed {
    uvsph_pkg::kind_t                kind;
    logic [uvsph_pkg::CRN_W-1:0]     first;
  } sb_t;

  localparam int SB = uvsph_pkg::SB_STAGES;

  logic                                en;
  logic                                second_pending;
  logic                                s0_valid_r;
  uvsph_pkg::item_t                    s0_item_r;
  logic [uvsph_pkg::REM_W-1:0]         th_rem, ph_rem, th_den, ph_den;
  logic [uvsph_pkg::QUO_W-1:0]         th_num, ph_num;
  logic [uvsph_pkg::PHASE_W-1:0]       th_phase, ph_phase, th_phase_c, ph_phase_c;
  logic signed [uvsph_pkg::NRM_W-1:0]  st, ct, sp, cp;
  logic                                sb_valid_r [SB];
  sb_t                                 sb_r       [SB];

  // Scaling stages
  logic [14:0]                         st_mag, ct_mag, sp_mag, cp_mag;
  logic [30:0]                         rs_r, pzp_r;
  logic [29:0]                         nxp_r, nyp_r;
  logic [14:0]                         cm_r, sm_r;
  logic                                sx1_r, sy1_r, sz1_r;
  logic signed [uvsph_pkg::NRM_W-1:0]  ct1_r;
  logic [45:0]                         pxp_r, pyp_r;
  logic [16:0]                         pz_mag;
  logic [15:0]                         nx_mag, ny_mag;
  logic signed [uvsph_pkg::POS_W-1:0]  pz_r;
  logic signed [uvsph_pkg::NRM_W-1:0]  nx_r, ny_r, nz_r;
  logic                                sx2_r, sy2_r;
  logic [16:0]                         px_mag, py_mag;

  // Result register
  logic                                out_strobe_r;
  uvsph_pkg::kind_t                    out_kind_r;
  logic signed [uvsph_pkg::POS_W-1:0]  out_pos_x_r, out_pos_y_r, out_pos_z_r;
  logic signed [uvsph_pkg::NRM_W-1:0]  out_norm_x_r, out_norm_y_r, out_norm_z_r;
  logic [uvsph_pkg::CRN_W-1:0]         out_a_r, out_b_r, out_c_r;
  logic                                out_last_r;

  // Freeze the pipeline while the second triangle of a quad goes out
  assign second_pending = out_strobe_r && (out_kind_r == uvsph_pkg::KIND_TRI) && !out_last_r;
  assign en             = !second_pending;
  assign pop            = en;

  // Dequeue stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= head.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0_item_r <= head.item;
    end
  end

  // Divider operands: theta = (lat*2^24 + L) / 2L, phi = (lon*2^24 + L/2) / L
  always_comb begin
    th_rem = uvsph_pkg::REM_W'(s0_item_r.lat[uvsph_pkg::IDX_W-1:1]);
    th_num = {s0_item_r.lat[0], 15'b0, lat_count};
    th_den = {lat_count, 1'b0};
    ph_rem = uvsph_pkg::REM_W'(s0_item_r.lon[uvsph_pkg::IDX_W-1:1]);
    ph_num = {s0_item_r.lon[0], 16'b0, lon_count[uvsph_pkg::CNT_W-1:1]};
    ph_den = {1'b0, lon_count};
  end

  uvsph_div u_div_theta (
    .clk    (clk),
    .en     (en),
    .rem_in (th_rem),
    .num_in (th_num),
    .den    (th_den),
    .phase  (th_phase)
  );

  uvsph_div u_div_phi (
    .clk    (clk),
    .en     (en),
    .rem_in (ph_rem),
    .num_in (ph_num),
    .den    (ph_den),
    .phase  (ph_phase)
  );

  // Cosine is sine a quarter turn ahead
  assign th_phase_c = th_phase + (uvsph_pkg::PHASE_W'(1) << uvsph_pkg::QTR_BITS);
  assign ph_phase_c = ph_phase + (uvsph_pkg::PHASE_W'(1) << uvsph_pkg::QTR_BITS);

  uvsph_sine u_sin_theta (.clk(clk), .en(en), .phase(th_phase),   .value(st));
  uvsph_sine u_cos_theta (.clk(clk), .en(en), .phase(th_phase_c), .value(ct));
  uvsph_sine u_sin_phi   (.clk(clk), .en(en), .phase(ph_phase),   .value(sp));
  uvsph_sine u_cos_phi   (.clk(clk), .en(en), .phase(ph_phase_c), .value(cp));

  // Sideband delay line matching the datapath
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SB; i++) begin
        sb_valid_r[i] <= 1'b0;
      end
    end else if (en) begin
      sb_valid_r[0] <= s0_valid_r;
      for (int i = 1; i < SB; i++) begin
        sb_valid_r[i] <= sb_valid_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sb_r[0].kind  <= s0_item_r.kind;
      sb_r[0].first <= s0_item_r.first;
      for (int i = 1; i < SB; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  // First scaling stage: magnitudes and first products
  always_comb begin
    st_mag = st[15] ? 15'(-st) : 15'(st);
    ct_mag = ct[15] ? 15'(-ct) : 15'(ct);
    sp_mag = sp[15] ? 15'(-sp) : 15'(sp);
    cp_mag = cp[15] ? 15'(-cp) : 15'(cp);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rs_r  <= 31'(sphere_radius) * 31'(st_mag);
      pzp_r <= 31'(sphere_radius) * 31'(ct_mag);
      nxp_r <= 30'(st_mag) * 30'(cp_mag);
      nyp_r <= 30'(st_mag) * 30'(sp_mag);
      cm_r  <= cp_mag;
      sm_r  <= sp_mag;
      sx1_r <= st[15] ^ cp[15];
      sy1_r <= st[15] ^ sp[15];
      sz1_r <= ct[15];
      ct1_r <= ct;
    end
  end

  // Second scaling stage: x/y position products, round z position and normals
  always_comb begin
    pz_mag = 17'((pzp_r + 31'd8192) >> 14);
    nx_mag = 16'((nxp_r + 30'd8192) >> 14);
    ny_mag = 16'((nyp_r + 30'd8192) >> 14);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pxp_r <= 46'(rs_r) * 46'(cm_r);
      pyp_r <= 46'(rs_r) * 46'(sm_r);
      pz_r  <= sz1_r ? -$signed(pz_mag) : $signed(pz_mag);
      nx_r  <= sx1_r ? -$signed(nx_mag) : $signed(nx_mag);
      ny_r  <= sy1_r ? -$signed(ny_mag) : $signed(ny_mag);
      nz_r  <= ct1_r;
      sx2_r <= sx1_r;
      sy2_r <= sy1_r;
    end
  end

  // Round x/y positions
  always_comb begin
    px_mag = 17'((pxp_r + (46'(1) << 27)) >> 28);
    py_mag = 17'((pyp_r + (46'(1) << 27)) >> 28);
  end

  // Result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else if (second_pending) begin
      out_strobe_r <= 1'b1;
    end else begin
      out_strobe_r <= sb_valid_r[SB-1];
    end
  end

  // Result payload
  always_ff @(posedge clk) begin
    if (second_pending) begin
      out_a_r    <= out_b_r;
      out_b_r    <= out_b_r + 17'd1;
      out_last_r <= 1'b1;
    end else begin
      out_kind_r   <= sb_r[SB-1].kind;
      out_pos_x_r  <= '0;
      out_pos_y_r  <= '0;
      out_pos_z_r  <= '0;
      out_norm_x_r <= '0;
      out_norm_y_r <= '0;
      out_norm_z_r <= '0;
      out_a_r      <= '0;
      out_b_r      <= '0;
      out_c_r      <= '0;
      out_last_r   <= 1'b1;
      unique case (sb_r[SB-1].kind)
        uvsph_pkg::KIND_VERTEX: begin
          out_pos_x_r  <= sx2_r ? -$signed(px_mag) : $signed(px_mag);
          out_pos_y_r  <= sy2_r ? -$signed(py_mag) : $signed(py_mag);
          out_pos_z_r  <= pz_r;
          out_norm_x_r <= nx_r;
          out_norm_y_r <= ny_r;
          out_norm_z_r <= nz_r;
        end
        uvsph_pkg::KIND_TRI: begin
          out_a_r    <= sb_r[SB-1].first;
          out_b_r    <= sb_r[SB-1].first + uvsph_pkg::CRN_W'(lon_count) + 17'd1;
          out_c_r    <= sb_r[SB-1].first + 17'd1;
          out_last_r <= 1'b0;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_strobe      = out_strobe_r;
  assign out_result_kind = out_kind_r;
  assign out_pos_x       = out_pos_x_r;
  assign out_pos_y       = out_pos_y_r;
  assign out_pos_z       = out_pos_z_r;
  assign out_norm_x      = out_norm_x_r;
  assign out_norm_y      = out_norm_y_r;
  assign out_norm_z      = out_norm_z_r;
  assign out_corner_a    = out_a_r;
  assign out_corner_b    = out_b_r;
  assign out_corner_c    = out_c_r;
  assign out_last        = out_last_r;

  `ASSERT_CLK(a_pair_second, second_pending |=> (out_strobe_r && (out_kind_r == uvsph_pkg::KIND_TRI) && out_last_r), "quad lost its second triangle")
  `ASSERT_CLK(a_hold_freeze, second_pending |=> $stable(sb_valid_r[SB-1]), "pipeline moved during pair output")

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// UV-sphere mesh generator testbench
// Drives vertex and quad requests over several sphere settings, predicts the
// vertex positions, normals and triangle indices, and checks every result in
// order against the predicted stream.
// ----------------------------------------------------------------------------
module tb;

  localparam longint unsigned PH_MASK = 64'hFF_FFFF;
  localparam int LIMIT_CYCLES = 400000;

  typedef struct packed {
    logic [uvsph_pkg::KIND_W-1:0] kind;
    logic [uvsph_pkg::POS_W-1:0]  px;
    logic [uvsph_pkg::POS_W-1:0]  py;
    logic [uvsph_pkg::POS_W-1:0]  pz;
    logic [uvsph_pkg::NRM_W-1:0]  nx;
    logic [uvsph_pkg::NRM_W-1:0]  ny;
    logic [uvsph_pkg::NRM_W-1:0]  nz;
    logic [uvsph_pkg::CRN_W-1:0]  ca;
    logic [uvsph_pkg::CRN_W-1:0]  cb;
    logic [uvsph_pkg::CRN_W-1:0]  cc;
    logic                         last;
  } mesh_res_t;

  // Sphere geometry predictor and queue of pending results
  class mesh_scoreboard;
    longint unsigned radius, lat_cnt, lon_cnt;
    mesh_res_t pending[$];
    int mismatches;

    function new();
      radius = 256; lat_cnt = 16; lon_cnt = 32; mismatches = 0;
    endfunction

    function void write_reg(int idx, longint unsigned val);
      if (idx == uvsph_pkg::REG_RADIUS) radius = val & 16'hFFFF;
      else if (idx == uvsph_pkg::REG_LAT_COUNT) lat_cnt = val & 9'h1FF;
      else if (idx == uvsph_pkg::REG_LON_COUNT) lon_cnt = val & 9'h1FF;
    endfunction

    function bit counts_ok();
      return lat_cnt != 0 && lon_cnt != 0 && lat_cnt <= uvsph_pkg::MAX_DIVISIONS &&
             lon_cnt <= uvsph_pkg::MAX_DIVISIONS;
    endfunction

    function longint unsigned qmul(longint unsigned a, longint unsigned b);
      return (a * b + (64'd1 << 29)) >> 30;
    endfunction

    // Add a result at the tail of the expected stream
    function void add_expected(mesh_res_t r);
      pending.insert(pending.size(), r);
    endfunction

    // Q1.14 sine of a 24-bit phase
    function longint sine14(longint unsigned ph);
      longint unsigned x, x2, t, s;
      logic [1:0] quad;
      ph = ph & PH_MASK;
      quad = ph[23:22];
      x = (ph & 64'h3F_FFFF) << 8;
      if (quad[0]) x = (64'd1 << 30) - x;
      x2 = qmul(x, x);
      t = uvsph_pkg::K_A7 - qmul(x2, uvsph_pkg::K_A9);
      t = uvsph_pkg::K_A5 - qmul(x2, t);
      t = uvsph_pkg::K_A3 - qmul(x2, t);
      t = uvsph_pkg::K_A1 - qmul(x2, t);
      s = (qmul(x, t) + (64'd1 << 15)) >> 16;
      if (s > 16384) s = 16384;
      return quad[1] ? -longint'(s) : longint'(s);
    endfunction

    // factor*a*b / 2^sh, rounded half away from zero
    function longint scale(longint unsigned f, longint a, longint b, int sh);
      longint unsigned m, r;
      m = f * longint'(a < 0 ? -a : a) * longint'(b < 0 ? -b : b);
      r = (m + (64'd1 << (sh - 1))) >> sh;
      return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
    endfunction

    function void note_request(bit func, longint unsigned lat, longint unsigned lon);
      mesh_res_t r;
      bit ok;
      longint unsigned th, ph, first, second;
      longint st, ct, sp, cp;
      r = '0;
      ok = counts_ok();
      if (!func) ok = ok && lat <= lat_cnt && lon <= lon_cnt;
      else ok = ok && lat < lat_cnt && lon < lon_cnt;
      if (!ok) begin
        r.kind = uvsph_pkg::KIND_ERR; r.last = 1;
        add_expected(r);
      end else if (!func) begin
        th = (((lat << 24) + lat_cnt) / (2 * lat_cnt)) & PH_MASK;
        ph = (((lon << 24) + lon_cnt / 2) / lon_cnt) & PH_MASK;
        st = sine14(th);
        ct = sine14(th + (64'd1 << 22));
        sp = sine14(ph);
        cp = sine14(ph + (64'd1 << 22));
        r.kind = uvsph_pkg::KIND_VERTEX;
        r.px = uvsph_pkg::POS_W'(scale(radius, st, cp, 28));
        r.py = uvsph_pkg::POS_W'(scale(radius, st, sp, 28));
        r.pz = uvsph_pkg::POS_W'(scale(radius, ct, 16384, 28));
        r.nx = uvsph_pkg::NRM_W'(scale(1, st, cp, 14));
        r.ny = uvsph_pkg::NRM_W'(scale(1, st, sp, 14));
        r.nz = uvsph_pkg::NRM_W'(ct);
        r.last = 1;
        add_expected(r);
      end else begin
        first = lat * (lon_cnt + 1) + lon;
        second = first + lon_cnt + 1;
        r.kind = uvsph_pkg::KIND_TRI;
        r.ca = uvsph_pkg::CRN_W'(first);
        r.cb = uvsph_pkg::CRN_W'(second);
        r.cc = uvsph_pkg::CRN_W'(first + 1);
        add_expected(r);
        r.ca = uvsph_pkg::CRN_W'(second);
        r.cb = uvsph_pkg::CRN_W'(second + 1);
        r.cc = uvsph_pkg::CRN_W'(first + 1);
        r.last = 1;
        add_expected(r);
      end
    endfunction

    function void check_result(mesh_res_t act);
      mesh_res_t exp_r;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", act);
        return;
      end
      exp_r = pending.pop_front();
      if (act !== exp_r) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp_r, act);
      end
    endfunction
  endclass

  logic clk = 0, rst_n = 0;
  logic start = 0, busy;
  logic in_func = 0;
  logic [uvsph_pkg::IDX_W-1:0] in_lat_index = '0, in_lon_index = '0;
  logic cfg_valid = 0, cfg_ready;
  logic [uvsph_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [uvsph_pkg::CFG_DAT_W-1:0] cfg_data = '0;
  logic out_strobe, out_last;
  logic [uvsph_pkg::KIND_W-1:0] out_result_kind;
  logic signed [uvsph_pkg::POS_W-1:0] out_pos_x, out_pos_y, out_pos_z;
  logic signed [uvsph_pkg::NRM_W-1:0] out_norm_x, out_norm_y, out_norm_z;
  logic [uvsph_pkg::CRN_W-1:0] out_corner_a, out_corner_b, out_corner_c;

  mesh_scoreboard sb = new();
  bit gaps_on = 1;
  int cycles = 0;

  uv_sphere_mesh_generator i_dut (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // Bound the run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Check each result transfer
  always @(posedge clk) begin
    if (rst_n && out_strobe)
      sb.check_result({out_result_kind, out_pos_x, out_pos_y, out_pos_z, out_norm_x,
                       out_norm_y, out_norm_z, out_corner_a, out_corner_b,
                       out_corner_c, out_last});
  end

  task automatic send_request(bit func, int lat, int lon);
    @(negedge clk);
    while (gaps_on && $urandom_range(99) < 35) begin
      start <= 0;
      @(negedge clk);
    end
    start <= 1;
    in_func <= func;
    in_lat_index <= lat[uvsph_pkg::IDX_W-1:0];
    in_lon_index <= lon[uvsph_pkg::IDX_W-1:0];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    sb.note_request(func, lat, lon);
  endtask

  task automatic write_reg(int idx, int val);
    @(negedge clk);
    start <= 0;
    cfg_valid <= 1;
    cfg_index <= idx[uvsph_pkg::CFG_IDX_W-1:0];
    cfg_data <= val[uvsph_pkg::CFG_DAT_W-1:0];
    forever begin
      @(posedge clk);
      if (cfg_ready) break;
    end
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 0;
  endtask

  // Hold until every result is in, then let the pipeline drain
  task automatic drain();
    @(negedge clk);
    start <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
  endtask

  task automatic set_sphere(int rad, int lat, int lon);
    drain();
    write_reg(uvsph_pkg::REG_RADIUS, rad);
    write_reg(uvsph_pkg::REG_LAT_COUNT, lat);
    write_reg(uvsph_pkg::REG_LON_COUNT, lon);
  endtask

  task automatic random_requests(int n);
    int lat, lon;
    bit func;
    for (int i = 0; i < n; i++) begin
      func = $urandom_range(1);
      if (sb.counts_ok() && $urandom_range(99) < 85) begin
        lat = $urandom_range(sb.lat_cnt - func);
        lon = $urandom_range(sb.lon_cnt - func);
      end else begin
        lat = $urandom_range(511);
        lon = $urandom_range(511);
      end
      send_request(func, lat, lon);
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // Directed: poles, seam, quadrants and out-of-range indices at reset settings
    send_request(0, 0, 0);
    send_request(0, 16, 32);
    send_request(0, 8, 0);
    send_request(0, 8, 8);
    send_request(0, 8, 16);
    send_request(0, 8, 24);
    send_request(0, 4, 5);
    send_request(0, 17, 0);
    send_request(0, 0, 33);
    send_request(0, 511, 511);
    send_request(1, 0, 0);
    send_request(1, 15, 31);
    send_request(1, 16, 0);
    send_request(1, 0, 32);
    send_request(1, 7, 5);
    send_request(1, 511, 511);

    random_requests(150);
    // Unknown register index is ignored
    drain();
    write_reg(3, 16'hFFFF);
    random_requests(40);

    set_sphere(0, 1, 1);           // zero radius, coarsest mesh
    send_request(0, 1, 1);
    send_request(1, 0, 0);
    random_requests(120);

    set_sphere(65535, 256, 256);   // largest radius and mesh
    send_request(0, 256, 256);
    send_request(0, 128, 64);
    send_request(1, 255, 255);
    send_request(0, 257, 0);
    gaps_on = 0;
    random_requests(250);
    gaps_on = 1;

    set_sphere(65535, 1, 256);
    random_requests(120);

    set_sphere(300, 0, 5);         // zero latitude count
    random_requests(60);

    set_sphere(100, 257, 10);      // latitude count above the limit
    random_requests(60);

    set_sphere(256, 3, 511);
    random_requests(60);

    for (int p = 0; p < 6; p++) begin
      set_sphere($urandom_range(65535), $urandom_range(1, 256), $urandom_range(1, 256));
      random_requests(130);
    end

    drain();
    if (sb.mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end
endmodule

>>> files.f
+incdir+src
src/uvsph_pkg.sv
src/uvsph_front.sv
src/uvsph_div.sv
src/uvsph_sine.sv
src/uvsph_back.sv
src/uv_sphere_mesh_generator.sv
tb/tb.sv
